FILE: rtl/pidc_pkg.sv
// ============================================================================
// pidc_pkg - shared types, codes and microcode for the PID axis block
// Control word layout, sequencer status, opcodes, jump conditions and the
// read-only microprogram that steps the datapath through one control update.
// ============================================================================
package pidc_pkg;

    // Datapath widths fixed by the field formats
    localparam int PROD_W = 44;  // product magnitude / dividend
    localparam int DVSR_W = 14;  // divisor (16000 or 16*ms)

    // Datapath operations
    typedef logic [3:0] op_t;
    localparam op_t OP_NOP       = 4'd0;
    localparam op_t OP_LOAD      = 4'd1;
    localparam op_t OP_MUL_KI    = 4'd2;
    localparam op_t OP_MUL_MS    = 4'd3;
    localparam op_t OP_DIV_INT   = 4'd4;
    localparam op_t OP_INT_ADD   = 4'd5;
    localparam op_t OP_MUL_KP    = 4'd6;
    localparam op_t OP_P_ADD     = 4'd7;
    localparam op_t OP_MUL_KD    = 4'd8;
    localparam op_t OP_MUL_K1000 = 4'd9;
    localparam op_t OP_DIV_DER   = 4'd10;
    localparam op_t OP_D_ADD     = 4'd11;
    localparam op_t OP_FINISH    = 4'd12;

    // Sequencer jump conditions
    typedef logic [2:0] jcond_t;
    localparam jcond_t J_NEXT     = 3'd0;  // go to next step
    localparam jcond_t J_HOLD_IN  = 3'd1;  // hold until an input transaction
    localparam jcond_t J_HOLD_DIV = 3'd2;  // hold while divider is busy
    localparam jcond_t J_MS0      = 3'd3;  // jump to target when elapsed_ms is zero
    localparam jcond_t J_HOLD_OUT = 3'd4;  // hold until output slot free, then jump
    localparam jcond_t J_JUMP     = 3'd5;  // unconditional jump

    // Program steps
    typedef logic [3:0] step_t;
    localparam step_t ST_LOAD     = 4'd0;
    localparam step_t ST_MUL_KI   = 4'd1;
    localparam step_t ST_MUL_MS   = 4'd2;
    localparam step_t ST_DIV_INT  = 4'd3;
    localparam step_t ST_WAIT_INT = 4'd4;
    localparam step_t ST_INT_ADD  = 4'd5;
    localparam step_t ST_MUL_KP   = 4'd6;
    localparam step_t ST_P_ADD    = 4'd7;
    localparam step_t ST_MUL_KD   = 4'd8;
    localparam step_t ST_MUL_1000 = 4'd9;
    localparam step_t ST_DIV_DER  = 4'd10;
    localparam step_t ST_WAIT_DER = 4'd11;
    localparam step_t ST_D_ADD    = 4'd12;
    localparam step_t ST_FINISH   = 4'd13;

    // Configuration register indexes
    typedef logic [1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_KP      = 2'd0;
    localparam cfg_idx_t CFG_KI      = 2'd1;
    localparam cfg_idx_t CFG_KD      = 2'd2;
    localparam cfg_idx_t CFG_MAX_INT = 2'd3;

    // One control word
    typedef struct packed {
        op_t    op;
        jcond_t jcond;
        step_t  target;
    } ctl_t;

    // Status seen by the sequencer
    typedef struct packed {
        logic in_valid;
        logic div_busy;
        logic ms_zero;
        logic out_free;
    } stat_t;

    // Microprogram ROM
    function automatic ctl_t ucode(step_t s);
        ctl_t c;
        case (s)
            ST_LOAD:     c = '{OP_LOAD,      J_HOLD_IN,  ST_LOAD};
            ST_MUL_KI:   c = '{OP_MUL_KI,    J_NEXT,     ST_LOAD};
            ST_MUL_MS:   c = '{OP_MUL_MS,    J_NEXT,     ST_LOAD};
            ST_DIV_INT:  c = '{OP_DIV_INT,   J_NEXT,     ST_LOAD};
            ST_WAIT_INT: c = '{OP_NOP,       J_HOLD_DIV, ST_LOAD};
            ST_INT_ADD:  c = '{OP_INT_ADD,   J_NEXT,     ST_LOAD};
            ST_MUL_KP:   c = '{OP_MUL_KP,    J_NEXT,     ST_LOAD};
            ST_P_ADD:    c = '{OP_P_ADD,     J_NEXT,     ST_LOAD};
            ST_MUL_KD:   c = '{OP_MUL_KD,    J_MS0,      ST_FINISH};
            ST_MUL_1000: c = '{OP_MUL_K1000, J_NEXT,     ST_LOAD};
            ST_DIV_DER:  c = '{OP_DIV_DER,   J_NEXT,     ST_LOAD};
            ST_WAIT_DER: c = '{OP_NOP,       J_HOLD_DIV, ST_LOAD};
            ST_D_ADD:    c = '{OP_D_ADD,     J_NEXT,     ST_LOAD};
            ST_FINISH:   c = '{OP_FINISH,    J_HOLD_OUT, ST_LOAD};
            default:     c = '{OP_NOP,       J_JUMP,     ST_LOAD};
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/pidc_seq.sv
// ============================================================================
// pidc_seq - microcode sequencer
// Step counter over the microprogram ROM; evaluates the jump condition of the
// current control word against datapath status.
// ============================================================================
module pidc_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  pidc_pkg::stat_t stat,
    output pidc_pkg::ctl_t  ctl
);
    import pidc_pkg::*;

    step_t step_reg;
    step_t step_next;

    // Current control word
    assign ctl = ucode(step_reg);

    // Next step selection
    always_comb
    begin
        step_next = step_t'(step_reg + 4'd1);
        case (ctl.jcond)
            J_NEXT:
            begin
                step_next = step_t'(step_reg + 4'd1);
            end
            J_HOLD_IN:
            begin
                if (!stat.in_valid)
                begin
                    step_next = step_reg;
                end
            end
            J_HOLD_DIV:
            begin
                if (stat.div_busy)
                begin
                    step_next = step_reg;
                end
            end
            J_MS0:
            begin
                if (stat.ms_zero)
                begin
                    step_next = ctl.target;
                end
            end
            J_HOLD_OUT:
            begin
                step_next = stat.out_free ? ctl.target : step_reg;
            end
            J_JUMP:
            begin
                step_next = ctl.target;
            end
            default:
            begin
                step_next = ST_LOAD;
            end
        endcase
    end

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_LOAD;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

FILE: rtl/pidc_div.sv
// ============================================================================
// pidc_div - iterative unsigned divider
// Restoring division, two quotient bits per cycle; busy while iterating,
// quotient valid once busy drops.
// ============================================================================
module pidc_div #(
    parameter int DIVIDEND_W = 44,
    parameter int DIVISOR_W  = 14
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic                  busy
);
    localparam int STEPS = (DIVIDEND_W + 1) / 2;
    localparam int PAD_W = 2 * STEPS;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] rem_next;
    logic [PAD_W-1:0]     quo_reg;
    logic [PAD_W-1:0]     quo_next;
    logic [DIVISOR_W-1:0] dvsr_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;

    logic [DIVISOR_W:0]   t1;
    logic [DIVISOR_W:0]   t2;
    logic [DIVISOR_W:0]   d1;
    logic [DIVISOR_W:0]   d2;
    logic                 ge1;
    logic                 ge2;
    logic [DIVISOR_W-1:0] r1;
    logic [PAD_W-1:0]     q1;

    // Two restoring steps per cycle
    always_comb
    begin
        t1  = {rem_reg, quo_reg[PAD_W-1]};
        ge1 = (t1 >= {1'b0, dvsr_reg});
        d1  = t1 - {1'b0, dvsr_reg};
        r1  = ge1 ? d1[DIVISOR_W-1:0] : t1[DIVISOR_W-1:0];
        q1  = {quo_reg[PAD_W-2:0], ge1};

        t2  = {r1, q1[PAD_W-1]};
        ge2 = (t2 >= {1'b0, dvsr_reg});
        d2  = t2 - {1'b0, dvsr_reg};
        rem_next = ge2 ? d2[DIVISOR_W-1:0] : t2[DIVISOR_W-1:0];
        quo_next = {q1[PAD_W-2:0], ge2};
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(STEPS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Remainder and quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            quo_reg  <= PAD_W'(dividend);
            dvsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient = quo_reg[DIVIDEND_W-1:0];
    assign busy     = busy_reg;

endmodule

FILE: rtl/pidc_datapath.sv
// ============================================================================
// pidc_datapath - PID arithmetic datapath
// Gain registers, error capture, shared multiplier, integral store with
// upper clamp and floor, term accumulator, output saturation and result register.
// ============================================================================
module pidc_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pidc_pkg::ctl_t                ctl,
    // input transaction
    input  logic                          in_valid,
    input  logic signed [15:0]            setpoint,
    input  logic signed [15:0]            measured_angle,
    input  logic [9:0]                    elapsed_ms,
    // configuration writes
    input  logic                          cfg_we,
    input  pidc_pkg::cfg_idx_t            cfg_index,
    input  logic [15:0]                   cfg_data,
    // divider
    output logic                          div_start,
    output logic [pidc_pkg::PROD_W-1:0]   div_dividend,
    output logic [pidc_pkg::DVSR_W-1:0]   div_divisor,
    input  logic [pidc_pkg::PROD_W-1:0]   div_quotient,
    // status
    output logic                          ms_zero,
    output logic                          out_free,
    // result
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [15:0]                   drive,
    output logic                          integral_clamped,
    output logic                          output_saturated
);
    import pidc_pkg::*;

    localparam logic [DVSR_W-1:0]   INT_DIVISOR = 14'd16000;
    localparam logic [16:0]         K1000       = 17'd1000;
    localparam logic signed [40:0]  INT_MIN     = {2'b11, 39'd0};
    localparam logic signed [41:0]  ACC_NEG_LIM = -42'sd65535;

    // configuration
    logic [15:0] kp_reg;
    logic [15:0] ki_reg;
    logic [15:0] kd_reg;
    logic [15:0] max_int_reg;

    // state
    logic signed [39:0] integral_reg;
    logic signed [16:0] prev_err_reg;

    // working registers
    logic [15:0]        err_mag_reg;
    logic               err_neg_reg;
    logic [16:0]        de_mag_reg;
    logic               de_neg_reg;
    logic [9:0]         ms_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               prod_neg_reg;
    logic               clamp_reg;
    logic signed [41:0] acc_reg;

    // result register
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [15:0] drive_reg;
    logic        clamp_out_reg;
    logic        sat_reg;

    logic               load;
    logic               write_out;
    logic signed [16:0] err_w;
    logic signed [16:0] err_inv_w;
    logic signed [17:0] de_w;
    logic signed [17:0] de_inv_w;

    logic [32:0]        mul_a;
    logic [16:0]        mul_b;
    logic               mul_en;
    logic [49:0]        mul_p;

    logic [41:0]        qmag_w;
    logic signed [41:0] qs_w;
    logic [41:0]        pmag_w;
    logic signed [41:0] pt_w;
    logic signed [40:0] sum_w;
    logic signed [40:0] limit_w;

    logic [15:0]        drive_w;
    logic               sat_w;

    assign load      = (ctl.op == OP_LOAD) && in_valid;
    assign out_free  = !out_valid_reg || out_ready;
    assign write_out = (ctl.op == OP_FINISH) && out_free;
    assign ms_zero   = (ms_reg == 10'd0);

    // Error and error difference at load
    always_comb
    begin
        err_w     = $signed({setpoint[15], setpoint}) -
                    $signed({measured_angle[15], measured_angle});
        err_inv_w = -err_w;
        de_w      = $signed({err_w[16], err_w}) - $signed({prev_err_reg[16], prev_err_reg});
        de_inv_w  = -de_w;
    end

    // Shared multiplier operand selection (magnitudes only)
    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        case (ctl.op)
            OP_MUL_KI:
            begin
                mul_a = {17'd0, ki_reg};
                mul_b = {1'b0, err_mag_reg};
            end
            OP_MUL_MS:
            begin
                mul_a = prod_reg[32:0];
                mul_b = {7'd0, ms_reg};
            end
            OP_MUL_KP:
            begin
                mul_a = {17'd0, kp_reg};
                mul_b = {1'b0, err_mag_reg};
            end
            OP_MUL_KD:
            begin
                mul_a = {17'd0, kd_reg};
                mul_b = de_mag_reg;
            end
            OP_MUL_K1000:
            begin
                mul_a = prod_reg[32:0];
                mul_b = K1000;
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    assign mul_p = 50'(mul_a) * 50'(mul_b);

    // Divider hookup
    assign div_start    = (ctl.op == OP_DIV_INT) || (ctl.op == OP_DIV_DER);
    assign div_dividend = prod_reg;
    assign div_divisor  = (ctl.op == OP_DIV_DER) ? {ms_reg, 4'd0} : INT_DIVISOR;

    // Signed terms from magnitude and sign; truncation toward zero is on the magnitude
    always_comb
    begin
        qmag_w  = {1'b0, div_quotient[40:0]};
        qs_w    = prod_neg_reg ? -$signed(qmag_w) : $signed(qmag_w);
        pmag_w  = {14'd0, prod_reg[31:4]};
        pt_w    = prod_neg_reg ? -$signed(pmag_w) : $signed(pmag_w);
        sum_w   = $signed({integral_reg[39], integral_reg}) + $signed(qs_w[40:0]);
        limit_w = $signed({9'd0, max_int_reg, 16'd0});
    end

    // Whole part of the sum, saturated to 16 bits
    always_comb
    begin
        if (acc_reg < ACC_NEG_LIM)
        begin
            drive_w = 16'd0;
            sat_w   = 1'b1;
        end
        else if (acc_reg[41])
        begin
            drive_w = 16'd0;
            sat_w   = 1'b0;
        end
        else if (acc_reg[41:32] != 10'd0)
        begin
            drive_w = 16'hFFFF;
            sat_w   = 1'b1;
        end
        else
        begin
            drive_w = acc_reg[31:16];
            sat_w   = 1'b0;
        end
    end

    assign out_valid_next = write_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    // Configuration, controller state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg        <= 16'd0;
            ki_reg        <= 16'd0;
            kd_reg        <= 16'd0;
            max_int_reg   <= 16'd400;
            integral_reg  <= '0;
            prev_err_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_KP:      kp_reg      <= cfg_data;
                    CFG_KI:      ki_reg      <= cfg_data;
                    CFG_KD:      kd_reg      <= cfg_data;
                    CFG_MAX_INT: max_int_reg <= cfg_data;
                    default:     kp_reg      <= kp_reg;
                endcase
            end
            if (load)
            begin
                prev_err_reg <= err_w;
            end
            // integral update with upper clamp and store floor
            if (ctl.op == OP_INT_ADD)
            begin
                if (sum_w > limit_w)
                begin
                    integral_reg <= limit_w[39:0];
                end
                else if (sum_w < INT_MIN)
                begin
                    integral_reg <= INT_MIN[39:0];
                end
                else
                begin
                    integral_reg <= sum_w[39:0];
                end
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and result payload registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            err_neg_reg <= err_w[16];
            err_mag_reg <= err_w[16] ? err_inv_w[15:0] : err_w[15:0];
            de_neg_reg  <= de_w[17];
            de_mag_reg  <= de_w[17] ? de_inv_w[16:0] : de_w[16:0];
            ms_reg      <= elapsed_ms;
        end
        if (mul_en)
        begin
            prod_reg <= mul_p[PROD_W-1:0];
        end
        case (ctl.op)
            OP_MUL_KI:  prod_neg_reg <= err_neg_reg;
            OP_MUL_KP:  prod_neg_reg <= err_neg_reg;
            OP_MUL_KD:  prod_neg_reg <= de_neg_reg;
            OP_INT_ADD: clamp_reg    <= (sum_w > limit_w);
            OP_P_ADD:   acc_reg      <= $signed({{2{integral_reg[39]}}, integral_reg}) + pt_w;
            OP_D_ADD:   acc_reg      <= acc_reg + qs_w;
            default:    clamp_reg    <= clamp_reg;
        endcase
        if (write_out)
        begin
            drive_reg     <= drive_w;
            clamp_out_reg <= clamp_reg;
            sat_reg       <= sat_w;
        end
    end

    assign out_valid        = out_valid_reg;
    assign drive            = drive_reg;
    assign integral_clamped = clamp_out_reg;
    assign output_saturated = sat_reg;

endmodule

FILE: rtl/pid_step_with_integral_clamp.sv
// ============================================================================
// pid_step_with_integral_clamp - one PID axis with anti-windup upper clamp
// A result follows each input transaction after two passes through the
// 2-bit-per-cycle divider (one pass when elapsed_ms is 0). One item is in
// work at a time; the next item is taken while the previous result waits
// in the output register.
// Reset: asynchronous, active low; gains clear to 0, max_integral to 400,
// integral and previous error to 0, output empty.
// ============================================================================
module pid_step_with_integral_clamp (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // [15:0] setpoint, [31:16] measured_angle,
                                       // [41:32] elapsed_ms, [47:42] zero
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [15:0] drive
    output logic [1:0]  m_axis_tuser,  // [0] integral_clamped, [1] output_saturated
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import pidc_pkg::*;

    ctl_t              ctl;
    stat_t             stat;
    logic              div_start;
    logic [PROD_W-1:0] div_dividend;
    logic [DVSR_W-1:0] div_divisor;
    logic [PROD_W-1:0] div_quotient;
    logic              div_busy;
    logic              ms_zero;
    logic              out_free;

    // Input is taken only in the load step
    assign s_axis_tready = (ctl.op == OP_LOAD);

    assign stat = '{in_valid: s_axis_tvalid, div_busy: div_busy,
                    ms_zero: ms_zero, out_free: out_free};

    pidc_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    pidc_div #(
        .DIVIDEND_W (PROD_W),
        .DIVISOR_W  (DVSR_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .busy     (div_busy)
    );

    pidc_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .in_valid         (s_axis_tvalid),
        .setpoint         ($signed(s_axis_tdata[15:0])),
        .measured_angle   ($signed(s_axis_tdata[31:16])),
        .elapsed_ms       (s_axis_tdata[41:32]),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .div_start        (div_start),
        .div_dividend     (div_dividend),
        .div_divisor      (div_divisor),
        .div_quotient     (div_quotient),
        .ms_zero          (ms_zero),
        .out_free         (out_free),
        .out_ready        (m_axis_tready),
        .out_valid        (m_axis_tvalid),
        .drive            (m_axis_tdata),
        .integral_clamped (m_axis_tuser[0]),
        .output_saturated (m_axis_tuser[1])
    );

endmodule

FILE: rtl/pidc_checker.sv
// ============================================================================
// pidc_checker - port-level assertions for the PID axis block
// Watches the stream ports over time; attached to the top level by bind.
// ============================================================================
module pidc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // A stalled result stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result payload changed while stalled");

    // One item in work at a time: ready drops after an input transaction
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in work");

    // Saturation flag only with drive at a rail
    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
            (m_axis_tdata == 16'h0000 || m_axis_tdata == 16'hFFFF))
        else $error("saturation flagged with drive off the rails");

endmodule

bind pid_step_with_integral_clamp pidc_checker u_pidc_checker (.*);

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - stream-level regression for the PID axis with integral clamp
// A queue of input transactions feeds a clocked driver; a clocked monitor
// compares each result with a local fixed-point model of the controller.
// Gains are changed between phases, only once every result has come back.
// ----------------------------------------------------------------------------
module tb;

    import pidc_pkg::*;

    // one input transaction, packed as on s_axis_tdata (less the zero pad)
    typedef struct packed {
        logic [9:0]         elapsed_ms;
        logic signed [15:0] measured;
        logic signed [15:0] setpoint;
    } axis_item_t;

    // one result transaction
    typedef struct packed {
        logic [15:0] drive;
        logic        clamped;
        logic        saturated;
    } ctl_out_t;

    localparam longint INTEG_FLOOR = -(longint'(1) << 39);

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;  // [15:0] setpoint, [31:16] measured_angle,
                                     // [41:32] elapsed_ms, [47:42] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;       // [15:0] drive
    logic [1:0]  m_axis_tuser;       // [0] integral_clamped, [1] output_saturated
    logic        cfg_we = 1'b0;
    cfg_idx_t    cfg_index = CFG_KP;
    logic [15:0] cfg_data = '0;

    // model state and register copies
    logic [15:0] gain_p, gain_i, gain_d, integ_limit;
    longint      integ_acc;
    longint      last_err;

    axis_item_t  pending_items[$];
    ctl_out_t    expected_results[$];
    logic        in_accepted = 1'b0;
    int          snd_idle_pct = 16;
    int          rcv_idle_pct = 67;
    int          err_count = 0;

    pid_step_with_integral_clamp DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        err_count++;
    endtask

    // One control update: integral with upper clamp and floor, P and D terms,
    // truncate to whole units and saturate. All divisions truncate toward zero.
    task automatic compute_control_step(input logic signed [15:0] sp,
                                        input logic signed [15:0] meas,
                                        input logic [9:0] ms,
                                        output ctl_out_t res);
        longint err;
        longint lim;
        longint p_term;
        longint d_term;
        longint whole;
        err = longint'(sp) - longint'(meas);
        lim = longint'(integ_limit) * 65536;
        res = '0;
        integ_acc = integ_acc + (longint'(gain_i) * err * longint'(ms)) / 16000;
        if (integ_acc > lim)
        begin
            integ_acc   = lim;
            res.clamped = 1'b1;
        end
        if (integ_acc < INTEG_FLOOR)
            integ_acc = INTEG_FLOOR;
        p_term = (longint'(gain_p) * err) / 16;
        if (ms == 0)
            d_term = 0;
        else
            d_term = (longint'(gain_d) * (err - last_err) * 1000) / (16 * longint'(ms));
        whole = (p_term + integ_acc + d_term) / 65536;
        if (whole < 0)
        begin
            res.drive     = 16'd0;
            res.saturated = 1'b1;
        end
        else if (whole > 65535)
        begin
            res.drive     = 16'hFFFF;
            res.saturated = 1'b1;
        end
        else
            res.drive = whole[15:0];
        last_err = err;
    endtask

    // Model: register writes and accepted inputs, sampled at the rising edge
    always @(posedge clk)
    begin
        ctl_out_t res;
        if (!rst_n)
        begin
            gain_p      <= '0;
            gain_i      <= '0;
            gain_d      <= '0;
            integ_limit <= 16'd400;
            integ_acc   = 0;
            last_err    = 0;
            in_accepted <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_KP:      gain_p      <= cfg_data;
                    CFG_KI:      gain_i      <= cfg_data;
                    CFG_KD:      gain_d      <= cfg_data;
                    CFG_MAX_INT: integ_limit <= cfg_data;
                    default: ;
                endcase
            end
            in_accepted <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
            begin
                compute_control_step(s_axis_tdata[15:0], s_axis_tdata[31:16],
                                     s_axis_tdata[41:32], res);
                expected_results.push_back(res);
            end
        end
    end

    // Monitor: compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        ctl_out_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf("unexpected result drive=%0d flags=%b",
                                          m_axis_tdata, m_axis_tuser));
            else
            begin
                want = expected_results.pop_front();
                if (m_axis_tdata !== want.drive)
                    report_mismatch($sformatf("drive expected %0d got %0d",
                                              want.drive, m_axis_tdata));
                if (m_axis_tuser[0] !== want.clamped)
                    report_mismatch($sformatf("integral_clamped expected %b got %b",
                                              want.clamped, m_axis_tuser[0]));
                if (m_axis_tuser[1] !== want.saturated)
                    report_mismatch($sformatf("output_saturated expected %b got %b",
                                              want.saturated, m_axis_tuser[1]));
            end
        end
    end

    // Driver: present the next queued item unless holding one not yet taken
    always @(negedge clk)
    begin
        axis_item_t it;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || in_accepted)
        begin
            if (pending_items.size() > 0 && $urandom_range(0, 99) >= snd_idle_pct)
            begin
                it = pending_items.pop_front();
                s_axis_tdata  <= {6'b0, it.elapsed_ms, it.measured, it.setpoint};
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver back-pressure
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_gains(input logic [15:0] p, input logic [15:0] i,
                             input logic [15:0] d, input logic [15:0] lim);
        write_reg(CFG_KP, p);
        write_reg(CFG_KI, i);
        write_reg(CFG_KD, d);
        write_reg(CFG_MAX_INT, lim);
    endtask

    task automatic push_item(input logic signed [15:0] sp, input logic signed [15:0] meas,
                             input logic [9:0] ms);
        axis_item_t it;
        it.setpoint   = sp;
        it.measured   = meas;
        it.elapsed_ms = ms;
        pending_items.push_back(it);
    endtask

    // wait until every queued item has been taken and every result has come;
    // checked at the rising edge so a valid driven at the last falling edge is seen
    task automatic drain;
        while (pending_items.size() != 0 || (s_axis_tvalid && !in_accepted)
               || expected_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [15:0] rand_gain();
        case ($urandom_range(0, 3))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Mostly tracking steps with a small error and short intervals,
    // with full-range and extreme values mixed in.
    function automatic axis_item_t rand_item();
        axis_item_t it;
        int         kind;
        int         ms_pick;
        kind    = $urandom_range(0, 9);
        ms_pick = $urandom_range(0, 99);
        it.setpoint = 16'($urandom);
        if (kind < 6)
            it.measured = it.setpoint + 16'($urandom_range(0, 2047)) - 16'sd1024;
        else if (kind < 9)
            it.measured = 16'($urandom);
        else
        begin
            it.setpoint = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            it.measured = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        end
        if (ms_pick < 10)
            it.elapsed_ms = 10'd0;
        else if (ms_pick < 70)
            it.elapsed_ms = 10'($urandom_range(1, 20));
        else
            it.elapsed_ms = 10'($urandom_range(0, 1023));
        return it;
    endfunction

    // Stimulus sequence
    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // small negative sum truncates to zero without saturation
        set_gains(16'd1, 16'd0, 16'd0, 16'd400);
        push_item(16'sd0, 16'sd16, 10'd0);
        push_item(-16'sd15, 16'sd0, 10'd3);
        drain();

        // full-scale errors wind the integral up into the clamp
        set_gains(16'd256, 16'hFFFF, 16'd256, 16'hFFFF);
        repeat (18) push_item(16'sh7FFF, 16'sh8000, 10'd1023);
        push_item(16'sh8000, 16'sh7FFF, 10'd1);
        push_item(16'sh7FFF, 16'sh8000, 10'd1);
        push_item(16'sd0, 16'sd0, 10'd0);
        push_item(16'sh8000, 16'sh8000, 10'd512);
        push_item(16'sh7FFF, 16'sh7FFF, 10'd1023);
        drain();

        // limit lowered below the stored integral: next step clamps
        write_reg(CFG_MAX_INT, 16'd100);
        push_item(16'sd0, 16'sd0, 10'd0);
        drain();

        // random phases; idle pattern moves on every two phases
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph == 2)
            begin
                snd_idle_pct = 67;
                rcv_idle_pct = 16;
            end
            else if (ph == 4)
            begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            set_gains(rand_gain(), rand_gain(), rand_gain(), rand_gain());
            repeat (150) pending_items.push_back(rand_item());
            drain();
            repeat (150) pending_items.push_back(rand_item());
            drain();
        end

        // drive the integral negative with full-scale errors, then mix in random items
        set_gains(16'd0, 16'hFFFF, 16'd0, 16'd0);
        repeat (10) push_item(16'sh8000, 16'sh7FFF, 10'd1023);
        repeat (40) pending_items.push_back(rand_item());
        drain();

        repeat (64) @(negedge clk);
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: sim.f
rtl/pidc_pkg.sv
rtl/pidc_seq.sv
rtl/pidc_div.sv
rtl/pidc_datapath.sv
rtl/pid_step_with_integral_clamp.sv
rtl/pidc_checker.sv
test/tb.sv
